// File: src/hdtr_pkg.sv
// Shared types, constants and character helpers of the heredoc token recognizer.
// No dependencies; every other file of the block but hdtr_ram refers to this package.
`default_nettype none

package hdtr_pkg;

   localparam int TAG_DEPTH       = 256;
   localparam int PREFIX_DEPTH    = 8;
   localparam int LENGTH_BITS     = 24;

   localparam int TAG_ADDR_BITS   = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
   localparam int TAG_CNT_BITS    = $clog2(TAG_DEPTH + 1);
   localparam int PREFIX_CNT_BITS = $clog2(PREFIX_DEPTH + 1);
   localparam int ENC_COUNT       = 4;
   localparam int PHASE_PASSES    = 4;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_START,
      PH_AFTER_DOLLAR,
      PH_WORD,
      PH_LT1,
      PH_LT2,
      PH_QUOTE_OR_TAG,
      PH_TAG_FIRST,
      PH_TAG,
      PH_CLOSE_QUOTE,
      PH_SPACES,
      PH_SLASH,
      PH_HDR_COMMENT,
      PH_BODY_LEAD,
      PH_MATCH,
      PH_TAIL,
      PH_SKIPLINE
   } phase_type;

   typedef enum logic [1:0] {
      VERD_NONE,
      VERD_ACCEPT,
      VERD_REJECT
   } verdict_type;

   typedef struct packed {
      logic                     wr_en;
      logic [TAG_ADDR_BITS-1:0] wr_addr;
      logic [7:0]               wr_data;
      logic [TAG_ADDR_BITS-1:0] rd_addr;
   } tag_mem_req_type;

   typedef struct packed {
      logic                   accepted;
      logic [LENGTH_BITS-1:0] token_length;
   } result_type;

   function automatic logic id_start(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
             || (b == 8'h5F);
   endfunction

   function automatic logic id_cont(input logic [7:0] b);
      return id_start(b) || ((b >= 8'h30) && (b <= 8'h39));
   endfunction

   function automatic logic inline_blank(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR);
   endfunction

   function automatic logic [PREFIX_CNT_BITS-1:0] enc_len(input logic [1:0] idx);
      logic [PREFIX_CNT_BITS-1:0] len;
      case (idx)
         2'd1:    len = PREFIX_CNT_BITS'(4);
         default: len = PREFIX_CNT_BITS'(5);
      endcase
      return len;
   endfunction

   function automatic logic [7:0] enc_char(input logic [1:0] idx,
                                           input logic [PREFIX_CNT_BITS-1:0] pos);
      logic [39:0] name;
      logic [7:0]  ch;
      case (idx)
         2'd0:    name = "ascii";
         2'd1:    name = {"utf8", 8'h00};
         2'd2:    name = "utf16";
         default: name = "utf32";
      endcase
      case (pos)
         PREFIX_CNT_BITS'(0): ch = name[39:32];
         PREFIX_CNT_BITS'(1): ch = name[31:24];
         PREFIX_CNT_BITS'(2): ch = name[23:16];
         PREFIX_CNT_BITS'(3): ch = name[15:8];
         PREFIX_CNT_BITS'(4): ch = name[7:0];
         default:             ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// File: src/heredoc_token_recognizer_unit.sv
// Top level of the heredoc token recognizer: sequencer, tag RAM, result queue.
// Depends on hdtr_pkg, hdtr_ram, hdtr_parser and hdtr_rsp_buf.
//
//   channel  direction  ports                                              handshake
//   req      in         req_start_attempt, req_end_of_input, req_byte_value  req_valid / req_stall
//   rsp      out        rsp_accepted, rsp_token_length                     rsp_valid / rsp_stall
//
// One byte transaction per cycle while req_stall is low; a verdict is queued in the cycle its
// byte is taken and shows on rsp from the registered queue head. The tag RAM read for the next
// closing-line compare is issued from the state being written, so its read adds no bubble.
// Reset clears the phase and counters; the tag RAM is not cleared.
// req_stall rises only when both result queue entries are occupied.
`default_nettype none

module heredoc_token_recognizer_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_start_attempt,
   input  wire logic                              req_end_of_input,
   input  wire logic [7:0]                        req_byte_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_accepted,
   output logic [hdtr_pkg::LENGTH_BITS-1:0]       rsp_token_length
);

   hdtr_pkg::tag_mem_req_type tag_req;
   hdtr_pkg::result_type      result;
   hdtr_pkg::result_type      rsp_data;
   logic [7:0]                tag_rd_data;
   logic                      result_valid;
   logic                      full;
   logic                      take;

   assign req_stall = full;
   assign take      = req_valid && !full;

   hdtr_ram #(
      .WIDTH (8),
      .DEPTH (hdtr_pkg::TAG_DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_req.wr_en),
      .wr_addr (tag_req.wr_addr),
      .wr_data (tag_req.wr_data),
      .rd_addr (tag_req.rd_addr),
      .rd_data (tag_rd_data)
   );

   hdtr_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .start_attempt (req_start_attempt),
      .end_of_input  (req_end_of_input),
      .byte_value    (req_byte_value),
      .tag_rd_data   (tag_rd_data),
      .tag_req       (tag_req),
      .result_valid  (result_valid),
      .result        (result)
   );

   hdtr_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_data (result),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_accepted     = rsp_data.accepted;
   assign rsp_token_length = rsp_data.token_length;

endmodule

`default_nettype wire

// File: src/hdtr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module hdtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/hdtr_parser.sv
// Per-byte phase sequencer: header parse, tag capture and closing-line match.
// Depends on hdtr_pkg; drives the tag RAM through hdtr_pkg::tag_mem_req_type.
`default_nettype none

module hdtr_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        take,
   input  wire logic                        start_attempt,
   input  wire logic                        end_of_input,
   input  wire logic [7:0]                  byte_value,
   input  wire logic [7:0]                  tag_rd_data,
   output hdtr_pkg::tag_mem_req_type        tag_req,
   output logic                             result_valid,
   output hdtr_pkg::result_type             result
);

   hdtr_pkg::phase_type                       phase_ff, phase_in;
   logic [hdtr_pkg::TAG_CNT_BITS-1:0]         tag_len_ff, tag_len_in;
   logic                                      quoted_ff, quoted_in;
   logic [hdtr_pkg::PREFIX_CNT_BITS-1:0]      pre_len_ff, pre_len_in;
   logic [hdtr_pkg::ENC_COUNT-1:0]            enc_hit_ff, enc_hit_in;
   logic [hdtr_pkg::TAG_CNT_BITS-1:0]         mcount_ff, mcount_in;
   logic [hdtr_pkg::LENGTH_BITS-1:0]          bcount_ff, bcount_in;
   logic [hdtr_pkg::LENGTH_BITS-1:0]          mend_ff, mend_in;

   hdtr_pkg::verdict_type                     verdict;
   logic                                      done;
   logic                                      known;
   logic                                      is_byte;
   logic                                      c_id_start;
   logic                                      c_id_cont;
   logic                                      c_blank;
   logic                                      wr_en;
   logic [hdtr_pkg::TAG_ADDR_BITS-1:0]        wr_addr;

   always_comb begin
      is_byte    = !end_of_input;
      c_id_start = is_byte && hdtr_pkg::id_start(byte_value);
      c_id_cont  = is_byte && hdtr_pkg::id_cont(byte_value);
      c_blank    = is_byte && hdtr_pkg::inline_blank(byte_value);

      phase_in   = phase_ff;
      tag_len_in = tag_len_ff;
      quoted_in  = quoted_ff;
      pre_len_in = pre_len_ff;
      enc_hit_in = enc_hit_ff;
      mcount_in  = mcount_ff;
      bcount_in  = bcount_ff;
      mend_in    = mend_ff;
      verdict    = hdtr_pkg::VERD_NONE;
      done       = 1'b0;
      known      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = tag_len_ff[hdtr_pkg::TAG_ADDR_BITS-1:0];

      if (take) begin
         if (start_attempt) begin
            phase_in   = hdtr_pkg::PH_START;
            tag_len_in = '0;
            quoted_in  = 1'b0;
            pre_len_in = '0;
            mcount_in  = '0;
            bcount_in  = '0;
            mend_in    = '0;
         end
         if (phase_in == hdtr_pkg::PH_IDLE) begin
            done = 1'b1;
         end else if (is_byte && (bcount_in != hdtr_pkg::LEN_MAX)) begin
            bcount_in = bcount_in + 1'b1;
         end

         for (int p = 0; p < hdtr_pkg::PHASE_PASSES; p++) begin
            if (!done) begin
               case (phase_in)
                  hdtr_pkg::PH_START: begin
                     phase_in = hdtr_pkg::PH_AFTER_DOLLAR;
                     if (is_byte && (byte_value == hdtr_pkg::CH_DOLLAR)) begin
                        done = 1'b1;
                     end
                  end
                  hdtr_pkg::PH_AFTER_DOLLAR: begin
                     if (c_id_start) begin
                        pre_len_in = '0;
                        enc_hit_in = '1;
                        phase_in   = hdtr_pkg::PH_WORD;
                     end else begin
                        phase_in = hdtr_pkg::PH_LT1;
                     end
                  end
                  hdtr_pkg::PH_WORD: begin
                     if (c_id_cont) begin
                        done = 1'b1;
                        if (pre_len_in >= hdtr_pkg::PREFIX_CNT_BITS'(hdtr_pkg::PREFIX_DEPTH))
                        begin
                           verdict = hdtr_pkg::VERD_REJECT;
                        end else begin
                           for (int e = 0; e < hdtr_pkg::ENC_COUNT; e++) begin
                              enc_hit_in[e] = enc_hit_in[e] && (byte_value ==
                                 hdtr_pkg::enc_char(2'(e), pre_len_in));
                           end
                           pre_len_in = pre_len_in + 1'b1;
                        end
                     end else begin
                        for (int e = 0; e < hdtr_pkg::ENC_COUNT; e++) begin
                           known = known || (enc_hit_in[e] &&
                              (pre_len_in == hdtr_pkg::enc_len(2'(e))));
                        end
                        if (known) begin
                           phase_in = hdtr_pkg::PH_LT1;
                        end else begin
                           done    = 1'b1;
                           verdict = hdtr_pkg::VERD_REJECT;
                        end
                     end
                  end
                  hdtr_pkg::PH_LT1, hdtr_pkg::PH_LT2: begin
                     done = 1'b1;
                     if (is_byte && (byte_value == hdtr_pkg::CH_LT)) begin
                        phase_in = (phase_in == hdtr_pkg::PH_LT1) ? hdtr_pkg::PH_LT2
                                                                  : hdtr_pkg::PH_QUOTE_OR_TAG;
                     end else begin
                        verdict = hdtr_pkg::VERD_REJECT;
                     end
                  end
                  hdtr_pkg::PH_QUOTE_OR_TAG: begin
                     phase_in = hdtr_pkg::PH_TAG_FIRST;
                     if (is_byte && (byte_value == hdtr_pkg::CH_QUOTE)) begin
                        quoted_in = 1'b1;
                        done      = 1'b1;
                     end
                  end
                  hdtr_pkg::PH_TAG_FIRST: begin
                     if (c_id_start) begin
                        tag_len_in = '0;
                        phase_in   = hdtr_pkg::PH_TAG;
                     end else begin
                        done    = 1'b1;
                        verdict = hdtr_pkg::VERD_REJECT;
                     end
                  end
                  hdtr_pkg::PH_TAG: begin
                     if (c_id_cont) begin
                        done = 1'b1;
                        if (tag_len_in >= hdtr_pkg::TAG_CNT_BITS'(hdtr_pkg::TAG_DEPTH)) begin
                           verdict = hdtr_pkg::VERD_REJECT;
                        end else begin
                           wr_en      = 1'b1;
                           wr_addr    = tag_len_in[hdtr_pkg::TAG_ADDR_BITS-1:0];
                           tag_len_in = tag_len_in + 1'b1;
                        end
                     end else begin
                        phase_in = quoted_in ? hdtr_pkg::PH_CLOSE_QUOTE : hdtr_pkg::PH_SPACES;
                     end
                  end
                  hdtr_pkg::PH_CLOSE_QUOTE: begin
                     done = 1'b1;
                     if (is_byte && (byte_value == hdtr_pkg::CH_QUOTE)) begin
                        phase_in = hdtr_pkg::PH_SPACES;
                     end else begin
                        verdict = hdtr_pkg::VERD_REJECT;
                     end
                  end
                  hdtr_pkg::PH_SPACES: begin
                     done = 1'b1;
                     if (c_blank) begin
                        phase_in = hdtr_pkg::PH_SPACES;
                     end else if (is_byte && (byte_value == hdtr_pkg::CH_HASH)) begin
                        phase_in = hdtr_pkg::PH_HDR_COMMENT;
                     end else if (is_byte && (byte_value == hdtr_pkg::CH_SLASH)) begin
                        phase_in = hdtr_pkg::PH_SLASH;
                     end else if (is_byte && (byte_value == hdtr_pkg::CH_NEWLINE)) begin
                        phase_in = hdtr_pkg::PH_BODY_LEAD;
                     end else begin
                        verdict = hdtr_pkg::VERD_REJECT;
                     end
                  end
                  hdtr_pkg::PH_SLASH: begin
                     done = 1'b1;
                     if (is_byte && (byte_value == hdtr_pkg::CH_SLASH)) begin
                        phase_in = hdtr_pkg::PH_HDR_COMMENT;
                     end else begin
                        verdict = hdtr_pkg::VERD_REJECT;
                     end
                  end
                  hdtr_pkg::PH_HDR_COMMENT, hdtr_pkg::PH_SKIPLINE: begin
                     done = 1'b1;
                     if (!is_byte) begin
                        verdict = hdtr_pkg::VERD_REJECT;
                     end else if (byte_value == hdtr_pkg::CH_NEWLINE) begin
                        phase_in = hdtr_pkg::PH_BODY_LEAD;
                     end
                  end
                  hdtr_pkg::PH_BODY_LEAD: begin
                     if (!is_byte) begin
                        done    = 1'b1;
                        verdict = hdtr_pkg::VERD_REJECT;
                     end else if ((byte_value == hdtr_pkg::CH_SPACE) ||
                                  (byte_value == hdtr_pkg::CH_TAB)) begin
                        done = 1'b1;
                     end else begin
                        mcount_in = '0;
                        phase_in  = hdtr_pkg::PH_MATCH;
                     end
                  end
                  hdtr_pkg::PH_MATCH: begin
                     if (is_byte && (mcount_in < tag_len_in) && (byte_value == tag_rd_data))
                     begin
                        done      = 1'b1;
                        mcount_in = mcount_in + 1'b1;
                        if (mcount_in >= tag_len_in) begin
                           mend_in  = bcount_in;
                           phase_in = hdtr_pkg::PH_TAIL;
                        end
                     end else begin
                        phase_in = hdtr_pkg::PH_SKIPLINE;
                     end
                  end
                  hdtr_pkg::PH_TAIL: begin
                     if (!is_byte || (byte_value == hdtr_pkg::CH_NEWLINE)) begin
                        done    = 1'b1;
                        verdict = hdtr_pkg::VERD_ACCEPT;
                     end else if (c_blank) begin
                        done = 1'b1;
                     end else begin
                        phase_in = hdtr_pkg::PH_SKIPLINE;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end

         if (verdict != hdtr_pkg::VERD_NONE) begin
            phase_in = hdtr_pkg::PH_IDLE;
         end
         if (phase_in != hdtr_pkg::PH_MATCH) begin
            mcount_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= hdtr_pkg::PH_IDLE;
         tag_len_ff <= '0;
         quoted_ff  <= 1'b0;
         pre_len_ff <= '0;
         enc_hit_ff <= '0;
         mcount_ff  <= '0;
         bcount_ff  <= '0;
         mend_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         tag_len_ff <= tag_len_in;
         quoted_ff  <= quoted_in;
         pre_len_ff <= pre_len_in;
         enc_hit_ff <= enc_hit_in;
         mcount_ff  <= mcount_in;
         bcount_ff  <= bcount_in;
         mend_ff    <= mend_in;
      end
   end

   // prefetch the tag byte that the next transaction compares against
   assign tag_req.wr_en   = wr_en;
   assign tag_req.wr_addr = wr_addr;
   assign tag_req.wr_data = byte_value;
   assign tag_req.rd_addr = mcount_in[hdtr_pkg::TAG_ADDR_BITS-1:0];

   assign result_valid        = verdict != hdtr_pkg::VERD_NONE;
   assign result.accepted     = verdict == hdtr_pkg::VERD_ACCEPT;
   assign result.token_length = (verdict == hdtr_pkg::VERD_ACCEPT) ? mend_in : '0;

endmodule

`default_nettype wire

// File: src/hdtr_rsp_buf.sv
// Two-entry result queue between the sequencer and the response channel.
// Depends on hdtr_pkg for hdtr_pkg::result_type.
`default_nettype none

module hdtr_rsp_buf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire hdtr_pkg::result_type  push_data,
   output logic                       full,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output hdtr_pkg::result_type       rsp_data
);

   hdtr_pkg::result_type slot0_ff, slot0_in;
   hdtr_pkg::result_type slot1_ff, slot1_in;
   logic [1:0]           count_ff, count_in;
   logic                 pop;

   always_comb begin
      pop      = (count_ff != 2'd0) && !rsp_stall;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_in = push_data;
            end else begin
               slot1_in = push_data;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = push_data;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_data;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign full      = count_ff == 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = slot0_ff;

endmodule

`default_nettype wire

// File: tb/sv/heredoc_verdict_pkg.sv
// Verdict predictor and checker for the heredoc token recognizer testbench.
// Depends on hdtr_pkg for the phase and verdict encodings and the block sizes.
package heredoc_verdict_pkg;
   import hdtr_pkg::*;

   typedef struct {
      logic                   accepted;
      logic [LENGTH_BITS-1:0] token_length;
   } heredoc_verdict_type;

   class heredoc_verdict_checker;
      phase_type              phase;
      logic [7:0]             tag_chars [TAG_DEPTH];
      int                     tag_len;
      bit                     quoted;
      logic [7:0]             word_chars [PREFIX_DEPTH];
      int                     word_len;
      int                     match_len;
      logic [LENGTH_BITS-1:0] byte_cnt;
      logic [LENGTH_BITS-1:0] close_end;
      heredoc_verdict_type    awaited [$];
      int                     verdict_count;
      int                     fail_count;

      function new();
         phase         = PH_IDLE;
         tag_len       = 0;
         quoted        = 1'b0;
         word_len      = 0;
         match_len     = 0;
         byte_cnt      = '0;
         close_end     = '0;
         verdict_count = 0;
         fail_count    = 0;
      endfunction

      function bit word_known();
         string names [4];
         bit    same;
         names = '{"ascii", "utf8", "utf16", "utf32"};
         foreach (names[i]) begin
            if (names[i].len() == word_len) begin
               same = 1'b1;
               for (int k = 0; k < word_len; k++) begin
                  if (8'(names[i][k]) != word_chars[k]) same = 1'b0;
               end
               if (same) return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function verdict_type advance(bit eoi, logic [7:0] b);
         bit lead, word_ch, blank, lead_blank, nl;
         lead       = !eoi && ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_");
         word_ch    = lead || (!eoi && b >= "0" && b <= "9");
         lead_blank = !eoi && (b == CH_SPACE || b == CH_TAB);
         blank      = lead_blank || (!eoi && b == CH_CR);
         nl         = !eoi && b == CH_NEWLINE;
         for (int n = 0; n < 8; n++) begin
            case (phase)
               PH_START: begin
                  phase = PH_AFTER_DOLLAR;
                  if (!eoi && b == CH_DOLLAR) return VERD_NONE;
               end
               PH_AFTER_DOLLAR: begin
                  if (lead) begin
                     word_len = 0;
                     phase    = PH_WORD;
                  end else begin
                     phase = PH_LT1;
                  end
               end
               PH_WORD: begin
                  if (word_ch) begin
                     if (word_len >= PREFIX_DEPTH) return VERD_REJECT;
                     word_chars[word_len] = b;
                     word_len++;
                     return VERD_NONE;
                  end
                  if (!word_known()) return VERD_REJECT;
                  phase = PH_LT1;
               end
               PH_LT1: begin
                  if (!eoi && b == CH_LT) begin
                     phase = PH_LT2;
                     return VERD_NONE;
                  end
                  return VERD_REJECT;
               end
               PH_LT2: begin
                  if (!eoi && b == CH_LT) begin
                     phase = PH_QUOTE_OR_TAG;
                     return VERD_NONE;
                  end
                  return VERD_REJECT;
               end
               PH_QUOTE_OR_TAG: begin
                  phase = PH_TAG_FIRST;
                  if (!eoi && b == CH_QUOTE) begin
                     quoted = 1'b1;
                     return VERD_NONE;
                  end
               end
               PH_TAG_FIRST: begin
                  if (!lead) return VERD_REJECT;
                  tag_len = 0;
                  phase   = PH_TAG;
               end
               PH_TAG: begin
                  if (word_ch) begin
                     if (tag_len >= TAG_DEPTH) return VERD_REJECT;
                     tag_chars[tag_len] = b;
                     tag_len++;
                     return VERD_NONE;
                  end
                  phase = quoted ? PH_CLOSE_QUOTE : PH_SPACES;
               end
               PH_CLOSE_QUOTE: begin
                  if (!eoi && b == CH_QUOTE) begin
                     phase = PH_SPACES;
                     return VERD_NONE;
                  end
                  return VERD_REJECT;
               end
               PH_SPACES: begin
                  if (blank) return VERD_NONE;
                  if (!eoi && b == CH_HASH) begin
                     phase = PH_HDR_COMMENT;
                     return VERD_NONE;
                  end
                  if (!eoi && b == CH_SLASH) begin
                     phase = PH_SLASH;
                     return VERD_NONE;
                  end
                  if (nl) begin
                     phase = PH_BODY_LEAD;
                     return VERD_NONE;
                  end
                  return VERD_REJECT;
               end
               PH_SLASH: begin
                  if (!eoi && b == CH_SLASH) begin
                     phase = PH_HDR_COMMENT;
                     return VERD_NONE;
                  end
                  return VERD_REJECT;
               end
               PH_HDR_COMMENT: begin
                  if (eoi) return VERD_REJECT;
                  if (nl) phase = PH_BODY_LEAD;
                  return VERD_NONE;
               end
               PH_BODY_LEAD: begin
                  if (eoi) return VERD_REJECT;
                  if (lead_blank) return VERD_NONE;
                  match_len = 0;
                  phase     = PH_MATCH;
               end
               PH_MATCH: begin
                  if (!eoi && match_len < tag_len && b == tag_chars[match_len]) begin
                     match_len++;
                     if (match_len >= tag_len) begin
                        close_end = byte_cnt;
                        phase     = PH_TAIL;
                     end
                     return VERD_NONE;
                  end
                  phase = PH_SKIPLINE;
               end
               PH_TAIL: begin
                  if (eoi || nl) return VERD_ACCEPT;
                  if (blank) return VERD_NONE;
                  phase = PH_SKIPLINE;
               end
               PH_SKIPLINE: begin
                  if (eoi) return VERD_REJECT;
                  if (nl) phase = PH_BODY_LEAD;
                  return VERD_NONE;
               end
               default: return VERD_NONE;
            endcase
         end
         return VERD_NONE;
      endfunction

      function void take_byte(bit start, bit eoi, logic [7:0] b);
         verdict_type         v;
         heredoc_verdict_type r;
         if (start) begin
            phase     = PH_START;
            tag_len   = 0;
            quoted    = 1'b0;
            word_len  = 0;
            match_len = 0;
            byte_cnt  = '0;
            close_end = '0;
         end
         if (phase == PH_IDLE) return;
         if (!eoi && byte_cnt != '1) byte_cnt = byte_cnt + 1'b1;
         v = advance(eoi, b);
         if (v == VERD_NONE) return;
         phase          = PH_IDLE;
         r.accepted     = (v == VERD_ACCEPT);
         r.token_length = r.accepted ? close_end : '0;
         awaited.push_back(r);
         verdict_count++;
      endfunction

      function void check_verdict(longint unsigned stamp, logic acc,
                                  logic [LENGTH_BITS-1:0] len);
         heredoc_verdict_type r;
         if (awaited.size() == 0) begin
            $display("%0d ns: verdict with none awaited: expected none, got accepted=%0b length=%0d",
                     stamp, acc, len);
            fail_count++;
            return;
         end
         r = awaited.pop_front();
         if (acc !== r.accepted) begin
            $display("%0d ns: accepted expected %0b, got %0b", stamp, r.accepted, acc);
            fail_count++;
         end
         if (len !== r.token_length) begin
            $display("%0d ns: token_length expected %0d, got %0d", stamp, r.token_length, len);
            fail_count++;
         end
      endfunction

      function int awaited_count();
         return awaited.size();
      endfunction
   endclass

endpackage

// File: tb/sv/tb_heredoc_token_recognizer_unit.sv
// Top of the heredoc token recognizer testbench: clock, reset, byte driver, verdict sink.
// Depends on hdtr_pkg, heredoc_verdict_pkg and the heredoc_token_recognizer_unit RTL.
module tb_heredoc_token_recognizer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import hdtr_pkg::*;
   import heredoc_verdict_pkg::*;

   localparam int ITEM_GOAL    = 1150;
   localparam int QUIET_AFTER  = 1080;
   localparam int PRESSURE_AT  = 950;
   localparam int LONG_HOLD    = 64;
   localparam int DRAIN_LIMIT  = 10000;
   localparam int SETTLE       = 10;

   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_stall;
   logic                   req_start_attempt = 1'b0;
   logic                   req_end_of_input  = 1'b0;
   logic [7:0]             req_byte_value    = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall         = 1'b0;
   logic                   rsp_accepted;
   logic [LENGTH_BITS-1:0] rsp_token_length;

   bit                     idle_bursts   = 1'b0;
   bit                     stall_bursts  = 1'b0;
   bit                     long_hold_due = 1'b0;
   int                     text_bytes    = 0;
   logic [7:0]             text_q [$];
   heredoc_verdict_checker verdicts;

   heredoc_token_recognizer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_attempt(req_start_attempt),
      .req_end_of_input (req_end_of_input),
      .req_byte_value   (req_byte_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_token_length (rsp_token_length)
   );

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            verdicts.take_byte(req_start_attempt, req_end_of_input, req_byte_value);
         if (rsp_valid && !rsp_stall)
            verdicts.check_verdict($time, rsp_accepted, rsp_token_length);
      end
   end

   initial begin
      int held;
      forever begin
         @(negedge clock);
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall <= 1'b1;
            for (held = 0; held < LONG_HOLD; held++) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_bursts && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #5ms;
      $display("heredoc_token_recognizer_unit verification failed");
      $finish;
   end

   task automatic offer(input bit first, input bit eoi, input logic [7:0] b);
      if (idle_bursts && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_start_attempt <= first;
      req_end_of_input  <= eoi;
      req_byte_value    <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_attempt(input bit close_eoi);
      foreach (text_q[i]) begin
         offer(i == 0, 1'b0, text_q[i]);
         text_bytes++;
      end
      if (close_eoi) begin
         offer(text_q.size() == 0, 1'b1, 8'($urandom_range(0, 255)));
         text_bytes++;
      end
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(8'(s[i]));
   endtask

   task automatic send_text(input string s, input bit close_eoi);
      text_q.delete();
      add_text(s);
      send_attempt(close_eoi);
   endtask

   task automatic add_blanks(input int n, input bit with_cr);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, with_cr ? 2 : 1);
         text_q.push_back(pick == 0 ? CH_SPACE : (pick == 1 ? CH_TAB : CH_CR));
      end
   endtask

   function automatic logic [7:0] rand_lead();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return 8'("_");
   endfunction

   function automatic logic [7:0] rand_cont();
      if ($urandom_range(0, 4) == 0) return 8'("0" + $urandom_range(0, 9));
      return rand_lead();
   endfunction

   function automatic logic [7:0] rand_line_byte();
      logic [7:0] r;
      do r = 8'($urandom_range(0, 255)); while (r == CH_NEWLINE);
      return r;
   endfunction

   task automatic send_long_tag(input int tag_size, input bit with_body);
      logic [7:0] tag [$];
      text_q.delete();
      add_text("<<");
      tag.push_back(rand_lead());
      repeat (tag_size - 1) tag.push_back(rand_cont());
      foreach (tag[i]) text_q.push_back(tag[i]);
      if (with_body) begin
         text_q.push_back(CH_NEWLINE);
         foreach (tag[i]) text_q.push_back(tag[i]);
         text_q.push_back(CH_NEWLINE);
      end
      send_attempt(1'b0);
   endtask

   task automatic build_heredoc(input int tag_size, output bit close_eoi);
      logic [7:0] tag [$];
      int         kind;
      int         n;
      bit         quoted;
      text_q.delete();
      close_eoi = 1'b0;
      if ($urandom_range(0, 1)) text_q.push_back(CH_DOLLAR);
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         case (kind)
            0: add_text("ascii");
            1: add_text("utf8");
            2: add_text("utf16");
            default: add_text("utf32");
         endcase
      end else if (kind < 7) begin
         n = (kind == 6) ? $urandom_range(PREFIX_DEPTH + 1, PREFIX_DEPTH + 2)
                         : $urandom_range(1, PREFIX_DEPTH);
         text_q.push_back(rand_lead());
         repeat (n - 1) text_q.push_back(rand_cont());
      end
      add_text("<<");
      quoted = ($urandom_range(0, 2) == 0);
      if (quoted) text_q.push_back(CH_QUOTE);
      tag.push_back(rand_lead());
      repeat (tag_size - 1) tag.push_back(rand_cont());
      foreach (tag[i]) text_q.push_back(tag[i]);
      if (quoted) text_q.push_back(CH_QUOTE);
      add_blanks($urandom_range(0, 2), 1'b1);
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            text_q.push_back(CH_HASH);
            repeat ($urandom_range(0, 6)) text_q.push_back(rand_line_byte());
         end
         3: begin
            add_text("//");
            repeat ($urandom_range(0, 6)) text_q.push_back(rand_line_byte());
         end
         4: begin
            text_q.push_back(CH_SLASH);
            text_q.push_back(rand_line_byte());
         end
         default: ;
      endcase
      text_q.push_back(CH_NEWLINE);
      repeat ($urandom_range(0, 3)) begin
         add_blanks($urandom_range(0, 2), 1'b0);
         case ($urandom_range(0, 4))
            0: repeat ($urandom_range(0, 8)) text_q.push_back(rand_line_byte());
            1: begin
               foreach (tag[i]) text_q.push_back(tag[i]);
               text_q.push_back(rand_cont());
            end
            2: begin
               n = $urandom_range(0, tag.size() - 1);
               for (int i = 0; i < n; i++) text_q.push_back(tag[i]);
               if ($urandom_range(0, 1)) text_q.push_back(rand_line_byte());
            end
            3: begin
               foreach (tag[i]) text_q.push_back(tag[i]);
               add_blanks($urandom_range(1, 2), 1'b1);
               text_q.push_back(8'("x"));
            end
            default: ;
         endcase
         text_q.push_back(CH_NEWLINE);
      end
      if ($urandom_range(0, 9) == 0) begin
         close_eoi = 1'b1;
      end else begin
         add_blanks($urandom_range(0, 2), 1'b0);
         foreach (tag[i]) text_q.push_back(tag[i]);
         add_blanks($urandom_range(0, 2), 1'b1);
         if ($urandom_range(0, 1)) text_q.push_back(CH_NEWLINE);
         else close_eoi = 1'b1;
      end
   endtask

   initial begin
      int choice;
      int cut;
      int drain;
      bit close_eoi;
      bit pressure_done;
      verdicts      = new();
      pressure_done = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset        <= 1'b0;
      idle_bursts  = 1'b1;
      stall_bursts = 1'b1;

      offer(1'b0, 1'b0, 8'h5A);
      offer(1'b0, 1'b1, 8'hA5);
      send_text("<<EOT\nEOT\n", 1'b0);
      send_text("$<<X\nX", 1'b1);
      send_text("utf8<<a\nb\n a\n", 1'b0);
      send_text("$utf16<<'q' //c\nq \015\t\n", 1'b0);
      send_text("utf32<<Z9#x\nZ9\n", 1'b0);
      send_text("ascii<<T\nTT\nT\015\n", 1'b0);
      send_text("abcdefghi<<", 1'b0);
      send_text("utf9<<T\nT\n", 1'b0);
      send_text("<<T / \n", 1'b0);
      send_text("<<T\nbody", 1'b1);
      send_text("<< T\n", 1'b0);
      send_text("<<'T\n", 1'b0);
      send_text("<", 1'b1);
      send_text("", 1'b1);
      send_text("$$<<", 1'b0);
      send_text("<<AB\nA", 1'b0);
      send_text("<<C\n\tC\n", 1'b0);
      send_text("<<E\n\377\200x\nE", 1'b1);
      send_long_tag(TAG_DEPTH, 1'b1);
      send_long_tag(TAG_DEPTH + 1, 1'b0);

      while (text_bytes < ITEM_GOAL) begin
         if (!pressure_done && text_bytes >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            long_hold_due = 1'b1;
            repeat (30) begin
               offer(1'b1, 1'b0, 8'($urandom_range(0, 35)));
               text_bytes++;
            end
         end
         if (text_bytes >= QUIET_AFTER) begin
            idle_bursts  = 1'b0;
            stall_bursts = 1'b0;
         end
         choice = $urandom_range(0, 9);
         if (choice < 7) begin
            build_heredoc(int'($urandom_range(1, 6)), close_eoi);
            if (text_q.size() > 0 && $urandom_range(0, 4) == 0)
               text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0) begin
               cut = $urandom_range(0, text_q.size());
               while (text_q.size() > cut) void'(text_q.pop_back());
               close_eoi = 1'($urandom_range(0, 1));
            end
            send_attempt(close_eoi);
         end else if (choice < 9) begin
            text_q.delete();
            repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) text_q[0] = CH_LT;
            send_attempt(1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 3))
               offer(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end

      idle_bursts  = 1'b0;
      stall_bursts = 1'b0;
      req_valid <= 1'b0;
      drain = 0;
      while (verdicts.awaited_count() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE) @(posedge clock);
      if (verdicts.awaited_count() == 0 && verdicts.fail_count == 0)
         $display("heredoc_token_recognizer_unit verification clean");
      else
         $display("heredoc_token_recognizer_unit verification failed");
      $finish;
   end

endmodule
